// ===== design/ttss_pkg.sv =====
// Shared types and codes for the tick task slot scheduler.
package ttss_pkg;

  // Request operations
  localparam logic OP_ATTACH = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // Task types
  localparam logic [1:0] KIND_ONESHOT  = 2'd0;
  localparam logic [1:0] KIND_ALWAYS   = 2'd1;
  localparam logic [1:0] KIND_PERIODIC = 2'd2;

  // Result kinds
  localparam logic [1:0] RK_ATTACHED = 2'd0;
  localparam logic [1:0] RK_REJECTED = 2'd1;
  localparam logic [1:0] RK_DUE      = 2'd2;
  localparam logic [1:0] RK_NONE     = 2'd3;

  // Most due results reported for one tick, and the width of their count
  localparam int MAX_RESULTS = 8;
  localparam int RES_CNT_W   = 4;

  typedef struct packed {
    logic        active;
    logic [1:0]  kind;
    logic [31:0] counter;
    logic [31:0] interval;
  } slot_entry_t;

  typedef struct packed {
    logic        due;
    slot_entry_t next;
  } slot_update_t;

endpackage

// ===== design/ttss_slot_update.sv =====
// Per-slot tick update: due check and counter step by task type.
module ttss_slot_update
  import ttss_pkg::*;
(
  input  slot_entry_t  entry,
  output slot_update_t upd
);

  logic [31:0] inc;

  assign inc = entry.counter + 32'd1;

  // Flag due, step the counter of an active slot and retire an active one-shot slot
  always_comb begin
    upd.due  = entry.active && (entry.counter == 32'd0);
    upd.next = entry;
    if (entry.active) begin
      case (entry.kind)
        KIND_ONESHOT: begin
          upd.next.active  = 1'b0;
          upd.next.counter = 32'd0;
        end
        KIND_ALWAYS: begin
          upd.next.counter = 32'd0;
        end
        KIND_PERIODIC: begin
          upd.next.counter = (inc > entry.interval) ? 32'd0 : inc;
        end
        default: begin
          upd.next.counter = entry.counter;
        end
      endcase
    end
  end

endmodule

// ===== design/tick_task_slot_scheduler.sv =====
// Tick task slot scheduler: slot table in one synchronous memory, walked per tick.
// Attach request: slot written on acceptance; the result is registered from the flush state.
// Tick request: one memory read and write-back per filled slot; output stalls pause the walk.
// One request is in flight at a time.
// Reset clears the fill count and control; slot memory is not cleared.
module tick_task_slot_scheduler
  import ttss_pkg::*;
#(
  parameter int SLOTS = 8
)
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        opcode,
  input  logic [1:0]  task_type,
  input  logic        task_active,
  input  logic [31:0] tick_interval,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  result_kind,
  output logic [2:0]  slot,
  output logic        last
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WALK  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]           state;
  logic [CW-1:0]        task_count;
  logic [CW-1:0]        nxt;
  logic [AW-1:0]        proc_idx;
  logic                 rd_v;
  logic                 have_pend;
  logic [1:0]           pend_kind;
  logic [2:0]           pend_slot;
  logic [RES_CNT_W-1:0] due_cnt;

  slot_entry_t mem [SLOTS];
  slot_entry_t rd_data;
  slot_entry_t mem_wdata;
  logic        mem_we;
  logic [AW-1:0] mem_waddr;
  logic        mem_re;

  slot_update_t upd;

  logic in_acc;
  logic table_full;
  logic out_free;
  logic due_ok;
  logic need_push;
  logic advance;
  logic walk_done;
  logic out_load;
  logic [1:0] out_kind_next;
  logic [2:0] out_slot_next;
  logic       out_last_next;

  ttss_slot_update u_update (
    .entry (rd_data),
    .upd   (upd)
  );

  assign in_stall   = (state != ST_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign table_full = (task_count >= CW'(SLOTS));
  assign out_free   = !out_valid || !out_stall;
  assign due_ok     = rd_v && upd.due && (due_cnt < RES_CNT_W'(MAX_RESULTS));
  assign need_push  = due_ok && have_pend;
  assign advance    = (state == ST_WALK) && (!need_push || out_free);
  assign walk_done  = advance && (nxt == task_count);
  assign mem_re     = advance && (nxt < task_count);

  // Select memory write: new slot on attach, write-back during the walk
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = proc_idx;
    mem_wdata = upd.next;
    if (in_acc && opcode == OP_ATTACH && !table_full) begin
      mem_we             = 1'b1;
      mem_waddr          = task_count[AW-1:0];
      mem_wdata.active   = task_active;
      mem_wdata.kind     = task_type;
      mem_wdata.counter  = 32'd0;
      mem_wdata.interval = tick_interval;
    end else if (advance && rd_v) begin
      mem_we = 1'b1;
    end
  end

  // Slot memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[nxt[AW-1:0]];
    end
  end

  // Choose what goes to the output register
  always_comb begin
    out_load      = 1'b0;
    out_kind_next = pend_kind;
    out_slot_next = pend_slot;
    out_last_next = 1'b0;
    if (advance && need_push) begin
      out_load = 1'b1;
    end else if (state == ST_FLUSH && out_free) begin
      out_load      = 1'b1;
      out_last_next = 1'b1;
      if (!have_pend) begin
        out_kind_next = RK_NONE;
        out_slot_next = 3'd0;
      end
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result_kind <= out_kind_next;
      slot        <= out_slot_next;
      last        <= out_last_next;
    end
  end

  // Sequence attach and tick requests
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      task_count <= '0;
      nxt        <= '0;
      rd_v       <= 1'b0;
      have_pend  <= 1'b0;
      due_cnt    <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (opcode == OP_ATTACH) begin
              have_pend <= 1'b1;
              state     <= ST_FLUSH;
              if (!table_full) begin
                task_count <= task_count + CW'(1);
              end
            end else begin
              have_pend <= 1'b0;
              nxt       <= '0;
              rd_v      <= 1'b0;
              due_cnt   <= '0;
              state     <= ST_WALK;
            end
          end
        end
        ST_WALK: begin
          if (advance) begin
            if (due_ok) begin
              have_pend <= 1'b1;
              due_cnt   <= due_cnt + RES_CNT_W'(1);
            end
            rd_v <= mem_re;
            if (mem_re) begin
              nxt <= nxt + CW'(1);
            end
            if (walk_done) begin
              state <= ST_FLUSH;
            end
          end
        end
        ST_FLUSH: begin
          if (out_free) begin
            have_pend <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Track the pending result and the slot in process
  always_ff @(posedge clk) begin
    if (in_acc && opcode == OP_ATTACH) begin
      if (!table_full) begin
        pend_kind <= RK_ATTACHED;
        pend_slot <= 3'(task_count);
      end else begin
        pend_kind <= RK_REJECTED;
        pend_slot <= 3'd0;
      end
    end else if (advance && due_ok) begin
      pend_kind <= RK_DUE;
      pend_slot <= 3'(proc_idx);
    end
    if (mem_re) begin
      proc_idx <= nxt[AW-1:0];
    end
  end

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    task_count <= CW'(SLOTS))
    else $error("slot fill count exceeds table size");

  a_idle_no_pend : assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !have_pend)
    else $error("pending result left behind in idle");

  a_walk_in_range : assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK && rd_v) |-> (CW'(proc_idx) < task_count))
    else $error("walk visits an unfilled slot");

  a_due_cap : assert property (@(posedge clk) disable iff (rst)
    due_cnt <= RES_CNT_W'(MAX_RESULTS))
    else $error("due result count exceeds cap");

  a_walk_ends_flush : assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK && walk_done) |=> state == ST_FLUSH)
    else $error("finished walk did not flush");
`endif

endmodule

// ===== tb/tb_tick_task_slot_scheduler.sv =====
// Self-checking testbench for the tick task slot scheduler: random traffic with stalls.
module tb_tick_task_slot_scheduler;
  timeunit 1ns;
  timeprecision 1ps;

  import ttss_pkg::*;

  localparam int SLOT_COUNT = 8;
  // Task type with no name in the package: due on every tick, counter never moves
  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam int RANDOM_ITEMS = 111;
  localparam int TAIL_ITEMS = 20;
  localparam int HOLD_AT = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_AT = 70;
  localparam int SETTLE_CYCLES = 20;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic        opcode;
    logic [1:0]  task_type;
    logic        task_active;
    logic [31:0] tick_interval;
  } sched_req_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] slot;
    logic       last;
  } sched_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        opcode = 1'b0;
  logic [1:0]  task_type = 2'd0;
  logic        task_active = 1'b0;
  logic [31:0] tick_interval = 32'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  result_kind;
  logic [2:0]  slot;
  logic        last;

  // Requests waiting to be offered, and scheduler results still to arrive
  sched_req_t    req_q[$];
  sched_result_t sched_results_q[$];

  // Mirror of the slot table
  int unsigned fill_count = 0;
  logic        slot_on[SLOT_COUNT];
  logic [1:0]  slot_type[SLOT_COUNT];
  logic [31:0] slot_ticks[SLOT_COUNT];
  logic [31:0] slot_period[SLOT_COUNT];

  sched_req_t cur_req;
  int         issued = 0;
  int         gap_left = 0;
  int         stall_left = 0;
  int         hold_left = 0;
  logic       hold_done = 1'b0;
  int         mismatches = 0;

  tick_task_slot_scheduler #(.SLOTS(SLOT_COUNT)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .opcode(opcode),
    .task_type(task_type),
    .task_active(task_active),
    .tick_interval(tick_interval),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .result_kind(result_kind),
    .slot(slot),
    .last(last)
  );

  always #10 clk = ~clk;

  function automatic sched_req_t make_req(input logic op, input logic [1:0] kind,
                                          input logic act, input logic [31:0] ival);
    sched_req_t r;
    r.opcode = op;
    r.task_type = kind;
    r.task_active = act;
    r.tick_interval = ival;
    return r;
  endfunction

  // Apply one request to the slot table mirror and queue the results it causes
  function automatic void step_scheduler(input sched_req_t req);
    int            n;
    sched_result_t held;
    logic          have_held;
    n = 0;
    have_held = 1'b0;
    if (req.opcode == OP_ATTACH) begin
      if (fill_count < SLOT_COUNT) begin
        slot_type[fill_count] = req.task_type;
        slot_on[fill_count] = req.task_active;
        slot_period[fill_count] = req.tick_interval;
        slot_ticks[fill_count] = 32'd0;
        sched_results_q.push_back(sched_result_t'{RK_ATTACHED, 3'(fill_count), 1'b1});
        fill_count++;
      end else begin
        sched_results_q.push_back(sched_result_t'{RK_REJECTED, 3'd0, 1'b1});
      end
    end else begin
      for (int i = 0; i < fill_count; i++) begin
        if (slot_on[i]) begin
          // report due slot; the previous one is not the final result
          if (slot_ticks[i] == 32'd0 && n < MAX_RESULTS) begin
            if (have_held) sched_results_q.push_back(held);
            held = sched_result_t'{RK_DUE, 3'(i), 1'b0};
            have_held = 1'b1;
            n++;
          end
          case (slot_type[i])
            KIND_ONESHOT: begin
              slot_on[i] = 1'b0;
              slot_ticks[i] = 32'd0;
            end
            KIND_ALWAYS: begin
              slot_ticks[i] = 32'd0;
            end
            KIND_PERIODIC: begin
              slot_ticks[i] = slot_ticks[i] + 32'd1;
              if (slot_ticks[i] > slot_period[i]) slot_ticks[i] = 32'd0;
            end
            default: begin
            end
          endcase
        end
      end
      if (have_held) begin
        held.last = 1'b1;
        sched_results_q.push_back(held);
      end else begin
        sched_results_q.push_back(sched_result_t'{RK_NONE, 3'd0, 1'b1});
      end
    end
  endfunction

  // Offer requests from the queue, with random gaps and one drain pause
  always @(posedge clk) begin : drive_requests
    logic taken;
    taken = in_valid && !in_stall;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (taken) step_scheduler(cur_req);
      if (!(in_valid && !taken)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (req_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (issued == DRAIN_AT && sched_results_q.size() != 0) begin
          // hold until every outstanding result has come back
          in_valid <= 1'b0;
        end else if (req_q.size() > TAIL_ITEMS && $urandom_range(0, 4) == 0) begin
          gap_left = $urandom_range(1, 11) - 1;
          in_valid <= 1'b0;
        end else begin
          cur_req = req_q.pop_front();
          issued++;
          in_valid <= 1'b1;
          opcode <= cur_req.opcode;
          task_type <= cur_req.task_type;
          task_active <= cur_req.task_active;
          tick_interval <= cur_req.tick_interval;
        end
      end
    end
  end

  // Stall the result side: random bursts plus one long hold
  always @(posedge clk) begin : drive_out_stall
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && issued >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (req_q.size() > TAIL_ITEMS && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 11) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Check each accepted result against the oldest outstanding one
  always @(posedge clk) begin : check_results
    sched_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (sched_results_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: kind %0d slot %0d last %0d",
                   result_kind, slot, last);
      end else begin
        want = sched_results_q.pop_front();
        if (result_kind !== want.kind || slot !== want.slot || last !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result mismatch: kind %0d/%0d slot %0d/%0d last %0d/%0d (exp/act)",
                     want.kind, result_kind, want.slot, slot, want.last, last);
        end
      end
    end
  end

  initial begin : run_test
    // empty table, then a table with one inactive slot and nothing due
    req_q.push_back(make_req(OP_TICK, 2'd0, 1'b0, 32'd0));
    req_q.push_back(make_req(OP_ATTACH, KIND_ALWAYS, 1'b0, 32'd0));
    req_q.push_back(make_req(OP_TICK, 2'd3, 1'b1, 32'hFFFF_FFFF));
    // periodic task with interval one: due, idle, due
    req_q.push_back(make_req(OP_ATTACH, KIND_PERIODIC, 1'b1, 32'd1));
    req_q.push_back(make_req(OP_TICK, 2'd0, 1'b0, 32'd0));
    req_q.push_back(make_req(OP_TICK, 2'd0, 1'b0, 32'd0));
    req_q.push_back(make_req(OP_TICK, 2'd0, 1'b0, 32'd0));
    // fill the rest of the table with every type and the interval extremes
    req_q.push_back(make_req(OP_ATTACH, KIND_ONESHOT, 1'b1, 32'hFFFF_FFFF));
    req_q.push_back(make_req(OP_ATTACH, KIND_SPARE, 1'b1, 32'hAAAA_AAAA));
    req_q.push_back(make_req(OP_ATTACH, KIND_PERIODIC, 1'b1, 32'hFFFF_FFFF));
    req_q.push_back(make_req(OP_ATTACH, KIND_ALWAYS, 1'b1, 32'h5555_5555));
    req_q.push_back(make_req(OP_ATTACH, KIND_ONESHOT, 1'b0, 32'd0));
    req_q.push_back(make_req(OP_ATTACH, KIND_PERIODIC, 1'b1, 32'd0));
    // full table rejects further attaches
    req_q.push_back(make_req(OP_ATTACH, KIND_SPARE, 1'b1, 32'hFFFF_FFFF));
    req_q.push_back(make_req(OP_TICK, 2'd0, 1'b0, 32'd0));
    req_q.push_back(make_req(OP_TICK, 2'd0, 1'b0, 32'd0));
    req_q.push_back(make_req(OP_ATTACH, KIND_ONESHOT, 1'b0, 32'd0));
    req_q.push_back(make_req(OP_TICK, 2'd0, 1'b0, 32'd0));
    req_q.push_back(make_req(OP_TICK, 2'd0, 1'b0, 32'd0));
    // random mix, ticks favored
    for (int k = 0; k < RANDOM_ITEMS; k++)
      req_q.push_back(make_req(($urandom_range(0, 9) < 6) ? OP_TICK : OP_ATTACH,
                               2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                               $urandom));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // wait for all requests to be taken, then for the results to drain
    while (req_q.size() != 0 || in_valid) @(posedge clk);
    while (sched_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb_tick_task_slot_scheduler passed");
    end else begin
      $display("tb_tick_task_slot_scheduler failed");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("tb_tick_task_slot_scheduler failed");
    $finish;
  end

endmodule

// ===== sim.f =====
design/ttss_pkg.sv
design/ttss_slot_update.sv
design/tick_task_slot_scheduler.sv
tb/tb_tick_task_slot_scheduler.sv
